// File: rtl/core/dgsp_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the dense graph shortest path block.
// Port widths, operation codes, scan phase codes and controller/datapath structs.
package dgsp_pkg;

	localparam int MAX_VERTICES_DEF  = 64;
	localparam int WEIGHT_BITS_DEF   = 16;
	localparam int DISTANCE_BITS_DEF = 22;

	localparam int OP_W          = 2;
	localparam int VTX_PORT_W    = 6;
	localparam int WEIGHT_PORT_W = 16;
	localparam int DIST_PORT_W   = 22;
	localparam int COUNT_W       = 7;

	localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_INIT  = 2'd0;
	localparam phase_t PH_RELAX = 2'd1;
	localparam phase_t PH_PICK  = 2'd2;
	localparam phase_t PH_EMIT  = 2'd3;

	typedef struct packed {
		logic   capture;
		logic   load_a;
		logic   load_b;
		logic   wipe_rst;
		logic   wipe;
		logic   scan_rst;
		logic   scan_go;
		phase_t phase;
		logic   seed;
		logic   take_pick;
	} ctrl_cmd_t;

	typedef struct packed {
		logic ep_ok;
		logic wipe_done;
		logic scan_done;
		logic pick_ok;
	} dp_status_t;

endpackage

// File: rtl/core/dgsp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for matrix wipe, edge load and the Dijkstra scan phases.
// Depends on dgsp_pkg; drives the datapath through ctrl_cmd_t only.
module dgsp_ctrl
	import dgsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OP_W-1:0]  operation,
	input  dp_status_t       status,
	output ctrl_cmd_t        cmd,
	output logic             busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WIPE  = 3'd1;
	localparam logic [2:0] ST_LOAD2 = 3'd2;
	localparam logic [2:0] ST_INIT  = 3'd3;
	localparam logic [2:0] ST_RELAX = 3'd4;
	localparam logic [2:0] ST_PICK  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd       = '0;
		cmd.phase = PH_INIT;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (operation)
						OP_CLEAR: begin
							cmd.wipe_rst = 1'b1;
							state_d      = ST_WIPE;
						end
						OP_LOAD: begin
							if (status.ep_ok) begin
								cmd.load_a = 1'b1;
								state_d    = ST_LOAD2;
							end
						end
						OP_RUN: begin
							cmd.scan_rst = 1'b1;
							state_d      = ST_INIT;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WIPE: begin
				cmd.wipe = 1'b1;
				if (status.wipe_done)
					state_d = ST_IDLE;
			end
			ST_LOAD2: begin
				cmd.load_b = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_INIT: begin
				cmd.phase = PH_INIT;
				if (status.scan_done) begin
					// vertex 0 is always the first pick
					cmd.seed     = 1'b1;
					cmd.scan_rst = 1'b1;
					state_d      = ST_RELAX;
				end else begin
					cmd.scan_go = 1'b1;
				end
			end
			ST_RELAX: begin
				cmd.phase = PH_RELAX;
				if (status.scan_done) begin
					cmd.scan_rst = 1'b1;
					state_d      = ST_PICK;
				end else begin
					cmd.scan_go = 1'b1;
				end
			end
			ST_PICK: begin
				cmd.phase = PH_PICK;
				if (status.scan_done) begin
					cmd.scan_rst = 1'b1;
					// an unknown pick means the rest is unreachable: report
					if (status.pick_ok) begin
						cmd.take_pick = 1'b1;
						state_d       = ST_RELAX;
					end else begin
						state_d = ST_EMIT;
					end
				end else begin
					cmd.scan_go = 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.phase = PH_EMIT;
				if (status.scan_done)
					state_d = ST_IDLE;
				else
					cmd.scan_go = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_WIPE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/core/dgsp_datapath.sv
`timescale 1ns / 1ps
// Weight matrix memory, per-vertex distance memory, scan counters and result registers.
// Depends on dgsp_pkg; takes commands from dgsp_ctrl.
module dgsp_datapath
	import dgsp_pkg::*;
#(
	parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [COUNT_W-1:0]       cfg_wr_data,
	input  logic [VTX_PORT_W-1:0]    from_vertex,
	input  logic [VTX_PORT_W-1:0]    to_vertex,
	input  logic [WEIGHT_PORT_W-1:0] edge_weight,
	input  ctrl_cmd_t                cmd,
	output dp_status_t               status,
	output logic                     result_strobe,
	output logic [VTX_PORT_W-1:0]    vertex_index,
	output logic [DIST_PORT_W-1:0]   path_distance,
	output logic                     reachable,
	output logic                     last_result
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int DB    = DISTANCE_BITS;
	localparam int WB    = WEIGHT_BITS;
	localparam int SW    = ((DB > WB) ? DB : WB) + 1;
	localparam logic [DB-1:0] DIST_MAX = '1;

	// configuration and active vertex count
	logic [COUNT_W-1:0] vcount_q;
	logic [CW-1:0]      n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vcount_q <= VCOUNT_RESET;
		else if (cfg_wr_en)
			vcount_q <= cfg_wr_data;
	end

	always_comb begin
		if (vcount_q == '0)
			n = CW'(1);
		else if (32'(vcount_q) > MAX_VERTICES)
			n = CW'(MAX_VERTICES);
		else
			n = CW'(vcount_q);
	end

	// edge load capture
	logic [VW-1:0] a_v, b_v, a_q, b_q;
	logic [WB-1:0] w_v, w_q;

	assign a_v = VW'(from_vertex);
	assign b_v = VW'(to_vertex);
	assign w_v = WB'(edge_weight);
	assign status.ep_ok = (32'(from_vertex) < MAX_VERTICES) &&
	                      (32'(to_vertex) < MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q <= a_v;
			b_q <= b_v;
			w_q <= w_v;
		end
	end

	// wipe sweep counter
	logic [AW-1:0] wcnt_q;

	assign status.wipe_done = (wcnt_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wcnt_q <= '0;
		else if (cmd.wipe_rst)
			wcnt_q <= '0;
		else if (cmd.wipe && !status.wipe_done)
			wcnt_q <= wcnt_q + AW'(1);
	end

	// scan counter and read stage
	logic [CW-1:0] j_q;
	logic          issue;
	logic          v_s1;
	logic [VW-1:0] j_s1;
	logic [VW-1:0] j_idx;

	assign j_idx = j_q[VW-1:0];
	assign issue = cmd.scan_go && (j_q < n);
	assign status.scan_done = (j_q == n) && !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q  <= '0;
			v_s1 <= 1'b0;
		end else if (cmd.scan_rst) begin
			j_q  <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (issue)
				j_q <= j_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_idx;
	end

	// adjacency matrix
	logic [WB-1:0] adj_mem [DEPTH];
	logic [WB-1:0] adj_rd_q;
	logic          adj_we;
	logic [AW-1:0] adj_waddr;
	logic [WB-1:0] adj_wdata;
	logic [AW-1:0] adj_raddr;
	logic [VW-1:0] x_q;
	logic [DB-1:0] xdist_q;

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = wcnt_q;
		adj_wdata = '0;
		if (cmd.wipe) begin
			adj_we = 1'b1;
		end else if (cmd.load_a) begin
			adj_we    = 1'b1;
			adj_waddr = AW'(a_v) * AW'(MAX_VERTICES) + AW'(b_v);
			adj_wdata = w_v;
		end else if (cmd.load_b) begin
			adj_we    = 1'b1;
			adj_waddr = AW'(b_q) * AW'(MAX_VERTICES) + AW'(a_q);
			adj_wdata = w_q;
		end
	end

	assign adj_raddr = AW'(x_q) * AW'(MAX_VERTICES) + AW'(j_idx);

	always_ff @(posedge clk) begin
		if (adj_we)
			adj_mem[adj_waddr] <= adj_wdata;
		adj_rd_q <= adj_mem[adj_raddr];
	end

	// per-vertex entry: visited, known, distance
	logic [DB+1:0] st_mem [MAX_VERTICES];
	logic [DB+1:0] st_rd_q;
	logic          st_we;
	logic [VW-1:0] st_waddr;
	logic [DB+1:0] st_wdata;
	logic          rd_vis, rd_known;
	logic [DB-1:0] rd_dist;
	logic [SW-1:0] sum;
	logic [DB-1:0] cand;

	assign rd_vis   = st_rd_q[DB+1];
	assign rd_known = st_rd_q[DB];
	assign rd_dist  = st_rd_q[DB-1:0];
	assign sum      = SW'(xdist_q) + SW'(adj_rd_q);
	assign cand     = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DB-1:0];

	always_comb begin
		st_we    = 1'b0;
		st_waddr = j_s1;
		st_wdata = st_rd_q;
		if (cmd.phase == PH_INIT && issue) begin
			st_we    = 1'b1;
			st_waddr = j_idx;
			st_wdata = {1'b0, (j_q == '0), {DB{1'b0}}};
		end else if (cmd.phase == PH_RELAX && v_s1) begin
			if (j_s1 == x_q) begin
				// mark the current vertex visited, keep its distance
				st_we    = 1'b1;
				st_wdata = {1'b1, rd_known, rd_dist};
			end else if (adj_rd_q != '0 && !rd_vis && (!rd_known || cand < rd_dist)) begin
				st_we    = 1'b1;
				st_wdata = {1'b0, 1'b1, cand};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[st_waddr] <= st_wdata;
		st_rd_q <= st_mem[j_idx];
	end

	// running minimum over unvisited vertices
	logic          best_v_q;
	logic          best_known_q;
	logic [VW-1:0] best_idx_q;
	logic [DB-1:0] best_dist_q;
	logic          take;

	assign take = (cmd.phase == PH_PICK) && v_s1 && !rd_vis &&
	              (!best_v_q || (rd_known && (!best_known_q || rd_dist < best_dist_q)));
	assign status.pick_ok = best_v_q && best_known_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			best_v_q <= 1'b0;
		else if (cmd.scan_rst)
			best_v_q <= 1'b0;
		else if (take)
			best_v_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_known_q <= rd_known;
			best_idx_q   <= j_s1;
			best_dist_q  <= rd_dist;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			x_q     <= '0;
			xdist_q <= '0;
		end else if (cmd.take_pick) begin
			x_q     <= best_idx_q;
			xdist_q <= best_dist_q;
		end
	end

	// result registers
	logic                   emit;
	logic                   strobe_q;
	logic [VTX_PORT_W-1:0]  index_q;
	logic [DIST_PORT_W-1:0] dist_q;
	logic                   reach_q;
	logic                   last_q;

	assign emit = (cmd.phase == PH_EMIT) && v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_q <= VTX_PORT_W'(j_s1);
			dist_q  <= rd_known ? DIST_PORT_W'(rd_dist) : '0;
			reach_q <= rd_known;
			last_q  <= ((CW'(j_s1) + CW'(1)) == n);
		end
	end

	assign result_strobe = strobe_q;
	assign vertex_index  = index_q;
	assign path_distance = dist_q;
	assign reachable     = reach_q;
	assign last_result   = last_q;

endmodule

// File: rtl/core/dense_graph_shortest_paths.sv
`timescale 1ns / 1ps
// Dense graph single-source shortest paths (Dijkstra over a weight matrix memory).
// Edge load: writes the from/to entry, then the to/from entry. Clear: one matrix entry a cycle.
// Run over n vertices: an init scan for setup, then a relax scan and a pick scan for each
// reachable vertex, then a scan of results, one beat per cycle, no stall.
// Reset: asynchronous; vertex_count returns to 64, then a wipe of the whole matrix, busy high.
module dense_graph_shortest_paths
	import dgsp_pkg::*;
#(
	parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          operation,
	input  logic [VTX_PORT_W-1:0]    from_vertex,
	input  logic [VTX_PORT_W-1:0]    to_vertex,
	input  logic [WEIGHT_PORT_W-1:0] edge_weight,
	input  logic                     cfg_wr_en,
	input  logic [COUNT_W-1:0]       cfg_wr_data,
	output logic                     result_strobe,
	output logic [VTX_PORT_W-1:0]    vertex_index,
	output logic [DIST_PORT_W-1:0]   path_distance,
	output logic                     reachable,
	output logic                     last_result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	dgsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	dgsp_datapath #(
		.MAX_VERTICES  (MAX_VERTICES),
		.WEIGHT_BITS   (WEIGHT_BITS),
		.DISTANCE_BITS (DISTANCE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.from_vertex   (from_vertex),
		.to_vertex     (to_vertex),
		.edge_weight   (edge_weight),
		.cmd           (cmd),
		.status        (status),
		.result_strobe (result_strobe),
		.vertex_index  (vertex_index),
		.path_distance (path_distance),
		.reachable     (reachable),
		.last_result   (last_result)
	);

	// results of one run come out as an unbroken burst
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_result |=> result_strobe)
		else $error("result burst broken before last beat");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_result |=> !result_strobe)
		else $error("result beat after last beat");

	a_mid_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_result |-> busy)
		else $error("idle while a run is still reporting");

	a_run_takes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_RUN |=> busy)
		else $error("run accepted without going busy");

endmodule
